[sv/bft_pkg.sv]
package bft_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int SLOT_W       = $clog2(FLOW_ENTRIES);
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int OUT_SLOT_W   = 10;

  localparam logic [15:0] IP_HDR_MIN  = 16'd20;
  localparam logic [15:0] FRAG_MASK   = 16'h1FFF;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] TCP_HDR_MIN = 16'd20;
  localparam logic [15:0] UDP_HDR_MIN = 16'd8;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_INVALID  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] low_addr;
    logic [31:0] high_addr;
    logic [15:0] low_port;
    logic [15:0] high_port;
  } flow_key_t;

  localparam int KEY_W = $bits(flow_key_t);

  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[OUT_SLOT_W-1:0];
  endfunction

endpackage

[sv/bidirectional_flow_table.sv]
// bidirectional five-tuple flow table
//
// input channel (in_*): one request carries the parsed ipv4 header fields
// and the l4 ports. a request is taken when in_valid is high and in_stall
// is low. in_stall is high from the cycle after a request is taken until
// its response has been taken, so one request is handled at a time.
// result channel (out_*): out_status and out_flow_slot, held stable while
// out_valid is high and out_stall is high.
// sequencing: a rejected header goes straight to the response; any other
// request first enters the scan state, where the key memory is read one
// slot per cycle over the used slots until a match is found; with no match
// the key is inserted at the fill count, or the table is full. the
// response is shown at least one cycle; once out_stall is low the block
// returns to idle, where the next request can be taken.
// the single read port of the key memory sets the scan rate.
// reset (rst_n low, synchronous) empties the table; stored keys are not
// cleared, slots at or above the fill count are never read.
// when the receiver stalls, the response holds and no request is taken.
module bidirectional_flow_table
  import bft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_avail_length,
  input  logic [3:0]            in_header_words,
  input  logic [15:0]           in_total_length,
  input  logic [15:0]           in_frag_field,
  input  logic [31:0]           in_source_addr,
  input  logic [31:0]           in_dest_addr,
  input  logic [7:0]            in_ip_protocol,
  input  logic [15:0]           in_source_port,
  input  logic [15:0]           in_dest_port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [OUT_SLOT_W-1:0] out_flow_slot
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  flow_key_t         key_r, key_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [SLOT_W-1:0] cmp_r, cmp_nxt;
  logic              pend_r, pend_nxt;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [5:0]        hdr_bytes;
  logic [15:0]       l4_len;
  logic              hdr_bad;
  logic              src_low;
  logic              use_ports;
  flow_key_t         in_key;

  logic              rd_en;
  logic              wr_en;
  logic [KEY_W-1:0]  rd_data;

  // header checks and direction-free key
  always_comb begin
    hdr_bytes = {in_header_words, 2'b00};
    hdr_bad   = (in_avail_length < IP_HDR_MIN) ||
                ({10'd0, hdr_bytes} > in_avail_length) ||
                (in_avail_length < in_total_length) ||
                ((in_frag_field & FRAG_MASK) != 16'd0);
    l4_len    = in_total_length - {10'd0, hdr_bytes};
    src_low   = in_source_addr < in_dest_addr;
    use_ports = ((in_ip_protocol == PROTO_TCP) && (l4_len >= TCP_HDR_MIN)) ||
                ((in_ip_protocol == PROTO_UDP) && (l4_len >= UDP_HDR_MIN));
    in_key.proto     = in_ip_protocol;
    in_key.low_addr  = src_low ? in_source_addr : in_dest_addr;
    in_key.high_addr = src_low ? in_dest_addr : in_source_addr;
    if (use_ports) begin
      in_key.low_port  = src_low ? in_source_port : in_dest_port;
      in_key.high_port = src_low ? in_dest_port : in_source_port;
    end else begin
      in_key.low_port  = 16'd0;
      in_key.high_port = 16'd0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    used_nxt   = used_r;
    iss_nxt    = iss_r;
    cmp_nxt    = cmp_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_key;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          if (hdr_bad) begin
            status_nxt = ST_INVALID;
            slot_nxt   = '0;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en    = iss_r < used_r;
        pend_nxt = rd_en;
        cmp_nxt  = iss_r[SLOT_W-1:0];
        if (rd_en) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (pend_r && (flow_key_t'(rd_data) == key_r)) begin
          status_nxt = ST_FOUND;
          slot_nxt   = cmp_r;
          pend_nxt   = 1'b0;
          state_nxt  = S_RESP;
        end else if (!rd_en && !pend_r) begin
          if (used_r == CNT_W'(FLOW_ENTRIES)) begin
            status_nxt = ST_FULL;
            slot_nxt   = '0;
          end else begin
            wr_en      = 1'b1;
            status_nxt = ST_INSERTED;
            slot_nxt   = used_r[SLOT_W-1:0];
            used_nxt   = used_r + CNT_W'(1);
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    iss_r    <= iss_nxt;
    cmp_r    <= cmp_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  bft_ram #(
    .WIDTH (KEY_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (used_r[SLOT_W-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (iss_r[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_RESP);
  assign out_status    = status_r;
  assign out_flow_slot = slot_out(slot_r);

endmodule

[sv/bft_ram.sv]
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bft_checker.sv]
module bft_checker
  import bft_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_status,
  input logic [OUT_SLOT_W-1:0] out_flow_slot
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_flow_slot))
    else $error("stalled response changed");

  // rejected or full responses carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INVALID || out_status == ST_FULL)
      |-> out_flow_slot == '0)
    else $error("nonzero slot on invalid or full response");

  // no request is taken while a response is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while response pending");

  // a taken request is never answered in the same cycle
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request not held off after accept");

  // reset leaves no response pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind bidirectional_flow_table bft_checker u_bft_checker (.*);
